FILE: sv/qprt_pkg.sv
// Shared types, constants and helpers for the queue pair ring tracker.
package qprt_pkg;

  // Largest ring the design may be asked for, and the cap the 8-bit pointers allow.
  localparam int unsigned MaxDepth  = 256;
  localparam int unsigned PtrCap    = (MaxDepth > 256) ? 256 : MaxDepth;

  localparam int unsigned PtrW      = 8;
  localparam int unsigned DepthW    = 9;
  localparam int unsigned OutstW    = 9;
  localparam int unsigned StatusW   = 16;
  localparam int unsigned CodeW     = 15;
  localparam int unsigned CmdIdW    = 16;
  localparam int unsigned ResultW   = 64;

  localparam logic [DepthW-1:0] DepthReset = DepthW'(256);
  localparam logic [DepthW-1:0] DepthCap   = DepthW'(PtrCap);
  localparam logic [DepthW-1:0] DepthMin   = DepthW'(2);
  localparam logic [OutstW-1:0] OutstMax   = '1;

  typedef enum logic [1:0] {
    REQ_SUBMIT   = 2'd0,
    REQ_FLUSH_SQ = 2'd1,
    REQ_OFFER_CQ = 2'd2,
    REQ_FLUSH_CQ = 2'd3
  } req_type_e;

  typedef enum logic {
    DB_SQ_TAIL = 1'b0,
    DB_CQ_HEAD = 1'b1
  } db_sel_e;

  typedef struct packed {
    req_type_e            req_type;
    logic [StatusW-1:0]   cqe_status;
    logic [PtrW-1:0]      cqe_sq_head;
    logic [CmdIdW-1:0]    cqe_command_id;
    logic [ResultW-1:0]   cqe_result;
  } qprt_req_t;

  typedef struct packed {
    logic                 accepted;
    logic                 queue_full;
    logic [PtrW-1:0]      sq_slot;
    logic                 doorbell_write;
    db_sel_e              doorbell_select;
    logic [PtrW-1:0]      doorbell_ptr;
    logic [CmdIdW-1:0]    cpl_command_id;
    logic [ResultW-1:0]   cpl_result;
    logic [CodeW-1:0]     cpl_status;
  } qprt_result_t;

  // Programmed depth clamped to the usable range.
  function automatic logic [DepthW-1:0] eff_depth(input logic [DepthW-1:0] depth);
    logic [DepthW-1:0] d;
    d = depth;
    if (d > DepthCap) d = DepthCap;
    if (d < DepthMin) d = DepthMin;
    return d;
  endfunction

  // Next ring pointer; anything reaching or passing the depth wraps to zero.
  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0]   ptr,
                                               input logic [DepthW-1:0] depth);
    logic [DepthW-1:0] nxt;
    nxt = {1'b0, ptr} + DepthW'(1);
    if (nxt >= depth) nxt = '0;
    return nxt[PtrW-1:0];
  endfunction

  function automatic logic ptr_wraps(input logic [PtrW-1:0]   ptr,
                                     input logic [DepthW-1:0] depth);
    return (({1'b0, ptr} + DepthW'(1)) >= depth);
  endfunction

endpackage

FILE: sv/qprt_engine.sv
// Pointer state and single-pass request evaluation.
module qprt_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  qprt_pkg::qprt_req_t      req_i,
  input  logic [qprt_pkg::DepthW-1:0] depth_i,
  output qprt_pkg::qprt_result_t   res_o
);

  logic [qprt_pkg::PtrW-1:0]   sub_tail_q,  sub_tail_d;
  logic [qprt_pkg::PtrW-1:0]   sub_head_q,  sub_head_d;
  logic [qprt_pkg::PtrW-1:0]   cpl_head_q,  cpl_head_d;
  logic                        cpl_phase_q, cpl_phase_d;
  logic [qprt_pkg::PtrW-1:0]   last_sq_db_q, last_sq_db_d;
  logic [qprt_pkg::PtrW-1:0]   last_cq_db_q, last_cq_db_d;
  logic [qprt_pkg::OutstW-1:0] outst_q,     outst_d;

  logic [qprt_pkg::PtrW-1:0]   tail_next;

  assign tail_next = qprt_pkg::next_ptr(sub_tail_q, depth_i);

  always_comb begin
    sub_tail_d   = sub_tail_q;
    sub_head_d   = sub_head_q;
    cpl_head_d   = cpl_head_q;
    cpl_phase_d  = cpl_phase_q;
    last_sq_db_d = last_sq_db_q;
    last_cq_db_d = last_cq_db_q;
    outst_d      = outst_q;
    res_o        = '0;
    if (valid_i) begin
      unique case (req_i.req_type)
        qprt_pkg::REQ_SUBMIT: begin
          if (tail_next == sub_head_q) begin
            res_o.queue_full = 1'b1;
          end else begin
            res_o.accepted = 1'b1;
            res_o.sq_slot  = sub_tail_q;
            sub_tail_d     = tail_next;
            if (outst_q != qprt_pkg::OutstMax) outst_d = outst_q + qprt_pkg::OutstW'(1);
          end
        end
        qprt_pkg::REQ_FLUSH_SQ: begin
          if (last_sq_db_q != sub_tail_q) begin
            res_o.doorbell_write  = 1'b1;
            res_o.doorbell_select = qprt_pkg::DB_SQ_TAIL;
            res_o.doorbell_ptr    = sub_tail_q;
            last_sq_db_d          = sub_tail_q;
          end
        end
        qprt_pkg::REQ_OFFER_CQ: begin
          if ((outst_q != '0) && (req_i.cqe_status[0] == cpl_phase_q)) begin
            res_o.accepted       = 1'b1;
            res_o.cpl_command_id = req_i.cqe_command_id;
            res_o.cpl_result     = req_i.cqe_result;
            res_o.cpl_status     = req_i.cqe_status[qprt_pkg::StatusW-1:1];
            sub_head_d           = req_i.cqe_sq_head;
            cpl_head_d           = qprt_pkg::next_ptr(cpl_head_q, depth_i);
            if (qprt_pkg::ptr_wraps(cpl_head_q, depth_i)) cpl_phase_d = ~cpl_phase_q;
            outst_d              = outst_q - qprt_pkg::OutstW'(1);
          end
        end
        qprt_pkg::REQ_FLUSH_CQ: begin
          if (last_cq_db_q != cpl_head_q) begin
            res_o.doorbell_write  = 1'b1;
            res_o.doorbell_select = qprt_pkg::DB_CQ_HEAD;
            res_o.doorbell_ptr    = cpl_head_q;
            last_cq_db_d          = cpl_head_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_tail_q   <= '0;
      sub_head_q   <= '0;
      cpl_head_q   <= '0;
      cpl_phase_q  <= 1'b1;
      last_sq_db_q <= '0;
      last_cq_db_q <= '0;
      outst_q      <= '0;
    end else begin
      sub_tail_q   <= sub_tail_d;
      sub_head_q   <= sub_head_d;
      cpl_head_q   <= cpl_head_d;
      cpl_phase_q  <= cpl_phase_d;
      last_sq_db_q <= last_sq_db_d;
      last_cq_db_q <= last_cq_db_d;
      outst_q      <= outst_d;
    end
  end

  // A request is never both taken and refused as full.
  a_acc_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.accepted && res_o.queue_full))
    else $error("accepted and queue_full together");

  // Phase flips only as the completion head wraps round to zero.
  a_phase_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cpl_phase_q != $past(cpl_phase_q)) |-> (cpl_head_q == '0))
    else $error("completion phase toggled without head wrap");

  // Outstanding count falls by exactly one per consumed completion.
  a_outst_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outst_q < $past(outst_q)) |-> (outst_q == $past(outst_q) - qprt_pkg::OutstW'(1)))
    else $error("outstanding count fell by more than one");

  // Submission tail moves only for a taken submit.
  a_tail_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_tail_q != $past(sub_tail_q)) |->
      $past(valid_i && (req_i.req_type == qprt_pkg::REQ_SUBMIT)))
    else $error("submission tail moved without a submit");

endmodule

FILE: sv/qprt_out_reg.sv
// Result register with one-cycle done strobe.
module qprt_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  qprt_pkg::qprt_result_t res_i,
  output logic                   done_o,
  output qprt_pkg::qprt_result_t res_o
);

  logic                   done_q;
  qprt_pkg::qprt_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_i;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: sv/queue_pair_ring_tracker.sv
// Top level of the submission/completion queue pair pointer tracker.
//
// One request is taken in every cycle that start_i is high (busy_o is
// always low), and its result appears on the result ports, flagged by
// done_o for a single cycle; the receiver cannot stall, so it must
// capture each result as it comes. Every request gives one result. The
// request is captured in an input register, evaluated in a single
// combinational pass against the pointer state, which is updated at the
// same edge the result register loads, so back-to-back requests always
// see the state left by their predecessor. Rate: one request per cycle;
// the input and result registers lie between a request and its result.
// The depth register may only be written while no request is in flight;
// programmed depths outside 2..256 are clamped.
module queue_pair_ring_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        req_type_i,
  input  logic [qprt_pkg::StatusW-1:0]      cqe_status_i,
  input  logic [qprt_pkg::PtrW-1:0]         cqe_sq_head_i,
  input  logic [qprt_pkg::CmdIdW-1:0]       cqe_command_id_i,
  input  logic [qprt_pkg::ResultW-1:0]      cqe_result_i,
  // result channel
  output logic                              done_o,
  output logic                              accepted_o,
  output logic                              queue_full_o,
  output logic [qprt_pkg::PtrW-1:0]         sq_slot_o,
  output logic                              doorbell_write_o,
  output logic                              doorbell_select_o,
  output logic [qprt_pkg::PtrW-1:0]         doorbell_ptr_o,
  output logic [qprt_pkg::CmdIdW-1:0]       cpl_command_id_o,
  output logic [qprt_pkg::ResultW-1:0]      cpl_result_o,
  output logic [qprt_pkg::CodeW-1:0]        cpl_status_o,
  // queue depth register write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qprt_pkg::DepthW-1:0]       cfg_queue_depth_i
);

  logic                              req_valid_q;
  qprt_pkg::qprt_req_t               req_q, req_d;
  logic [qprt_pkg::DepthW-1:0]       depth_q;
  logic [qprt_pkg::DepthW-1:0]       depth_eff;
  logic                              req_take;
  qprt_pkg::qprt_result_t            eng_res;
  qprt_pkg::qprt_result_t            out_res;

  // Never stalls: a request can enter every cycle.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign req_take    = start_i && !busy_o;

  always_comb begin
    req_d                = req_q;
    req_d.req_type       = qprt_pkg::req_type_e'(req_type_i);
    req_d.cqe_status     = cqe_status_i;
    req_d.cqe_sq_head    = cqe_sq_head_i;
    req_d.cqe_command_id = cqe_command_id_i;
    req_d.cqe_result     = cqe_result_i;
  end

  // Depth register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= qprt_pkg::DepthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      depth_q <= cfg_queue_depth_i;
    end
  end

  assign depth_eff = qprt_pkg::eff_depth(depth_q);

  // Input register: valid under reset, payload only loads on a request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q <= req_d;
    end
  end

  qprt_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_q),
    .req_i   (req_q),
    .depth_i (depth_eff),
    .res_o   (eng_res)
  );

  qprt_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_q),
    .res_i   (eng_res),
    .done_o  (done_o),
    .res_o   (out_res)
  );

  assign accepted_o        = out_res.accepted;
  assign queue_full_o      = out_res.queue_full;
  assign sq_slot_o         = out_res.sq_slot;
  assign doorbell_write_o  = out_res.doorbell_write;
  assign doorbell_select_o = out_res.doorbell_select;
  assign doorbell_ptr_o    = out_res.doorbell_ptr;
  assign cpl_command_id_o  = out_res.cpl_command_id;
  assign cpl_result_o      = out_res.cpl_result;
  assign cpl_status_o      = out_res.cpl_status;

endmodule

FILE: tb/tb_queue_pair_ring_tracker.sv
// Self-checking testbench for the queue pair ring tracker: directed table, random phases, saturation.
`timescale 1ns / 100ps

module tb_queue_pair_ring_tracker;

  // Longest legal quiet stretch is a sender gap of 19, the pass through the input and
  // result registers and a depth write, so this limit leaves a wide margin before declaring a hang.
  localparam int unsigned StallLimit = 400;
  localparam int unsigned ReportMax  = 10;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One line of the directed table: either a request or a depth write.
  typedef struct packed {
    row_kind_e                   kind;
    logic [qprt_pkg::DepthW-1:0] depth;
    qprt_pkg::qprt_req_t         rq;
    bit                          typed;
    qprt_pkg::qprt_result_t      want;
  } plan_row_t;

  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          start_i           = 1'b0;
  logic [1:0]                    req_type_i        = '0;
  logic [qprt_pkg::StatusW-1:0]  cqe_status_i      = '0;
  logic [qprt_pkg::PtrW-1:0]     cqe_sq_head_i     = '0;
  logic [qprt_pkg::CmdIdW-1:0]   cqe_command_id_i  = '0;
  logic [qprt_pkg::ResultW-1:0]  cqe_result_i      = '0;
  logic                          cfg_valid_i       = 1'b0;
  logic [qprt_pkg::DepthW-1:0]   cfg_queue_depth_i = qprt_pkg::DepthReset;

  logic                          busy_o;
  logic                          done_o;
  logic                          accepted_o;
  logic                          queue_full_o;
  logic [qprt_pkg::PtrW-1:0]     sq_slot_o;
  logic                          doorbell_write_o;
  logic                          doorbell_select_o;
  logic [qprt_pkg::PtrW-1:0]     doorbell_ptr_o;
  logic [qprt_pkg::CmdIdW-1:0]   cpl_command_id_o;
  logic [qprt_pkg::ResultW-1:0]  cpl_result_o;
  logic [qprt_pkg::CodeW-1:0]    cpl_status_o;
  logic                          cfg_ready_o;

  queue_pair_ring_tracker u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .req_type_i        (req_type_i),
    .cqe_status_i      (cqe_status_i),
    .cqe_sq_head_i     (cqe_sq_head_i),
    .cqe_command_id_i  (cqe_command_id_i),
    .cqe_result_i      (cqe_result_i),
    .done_o            (done_o),
    .accepted_o        (accepted_o),
    .queue_full_o      (queue_full_o),
    .sq_slot_o         (sq_slot_o),
    .doorbell_write_o  (doorbell_write_o),
    .doorbell_select_o (doorbell_select_o),
    .doorbell_ptr_o    (doorbell_ptr_o),
    .cpl_command_id_o  (cpl_command_id_o),
    .cpl_result_o      (cpl_result_o),
    .cpl_status_o      (cpl_status_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_queue_depth_i (cfg_queue_depth_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the pointer state, held at reset values until the first request.
  logic [qprt_pkg::PtrW-1:0]   ring_sq_tail   = '0;
  logic [qprt_pkg::PtrW-1:0]   ring_sq_head   = '0;
  logic [qprt_pkg::PtrW-1:0]   ring_cq_head   = '0;
  logic                        ring_cq_phase  = 1'b1;
  logic [qprt_pkg::PtrW-1:0]   ring_sq_db     = '0;
  logic [qprt_pkg::PtrW-1:0]   ring_cq_db     = '0;
  logic [qprt_pkg::OutstW-1:0] ring_inflight  = '0;
  logic [qprt_pkg::DepthW-1:0] ring_depth_reg = qprt_pkg::DepthReset;

  qprt_pkg::qprt_result_t resp_due [$];        // responses owed by the block, oldest first
  plan_row_t              directed_plan [$];
  int unsigned            fault_count  = 0;
  int unsigned            quiet_cycles = 0;
  bit                     no_gaps      = 1'b0;

  logic [qprt_pkg::DepthW-1:0] phase_depths [12] = '{9'd2, 9'd3, 9'd256, 9'd5, 9'd1, 9'd8,
                                                     9'd511, 9'd255, 9'd16, 9'd300, 9'd0,
                                                     9'd129};
  int unsigned                 submit_mix [3]    = '{70, 45, 30};

  // Works out the response to one request and moves the shadow state on.
  function automatic qprt_pkg::qprt_result_t ring_response(input qprt_pkg::qprt_req_t rq);
    qprt_pkg::qprt_result_t r;
    int unsigned            lim;
    int unsigned            nxt;
    r   = '0;
    lim = ring_depth_reg;
    if (lim > 256) lim = 256;
    if (lim < 2) lim = 2;
    case (rq.req_type)
      qprt_pkg::REQ_SUBMIT: begin
        nxt = ring_sq_tail + 1;
        if (nxt >= lim) nxt = 0;
        if (nxt == ring_sq_head) begin
          r.queue_full = 1'b1;
        end else begin
          r.accepted = 1'b1;
          r.sq_slot  = ring_sq_tail;
          ring_sq_tail = 8'(nxt);
          if (ring_inflight != qprt_pkg::OutstMax) begin
            ring_inflight = ring_inflight + qprt_pkg::OutstW'(1);
          end
        end
      end
      qprt_pkg::REQ_FLUSH_SQ: begin
        if (ring_sq_db != ring_sq_tail) begin
          r.doorbell_write  = 1'b1;
          r.doorbell_select = qprt_pkg::DB_SQ_TAIL;
          r.doorbell_ptr    = ring_sq_tail;
          ring_sq_db = ring_sq_tail;
        end
      end
      qprt_pkg::REQ_OFFER_CQ: begin
        if (ring_inflight != '0 && rq.cqe_status[0] == ring_cq_phase) begin
          r.accepted       = 1'b1;
          r.cpl_command_id = rq.cqe_command_id;
          r.cpl_result     = rq.cqe_result;
          r.cpl_status     = rq.cqe_status[15:1];
          ring_sq_head = rq.cqe_sq_head;   // taken as reported, even past the depth
          nxt = ring_cq_head + 1;
          if (nxt >= lim) begin
            nxt = 0;
            ring_cq_phase = ~ring_cq_phase;
          end
          ring_cq_head  = 8'(nxt);
          ring_inflight = ring_inflight - qprt_pkg::OutstW'(1);
        end
      end
      default: begin
        if (ring_cq_db != ring_cq_head) begin
          r.doorbell_write  = 1'b1;
          r.doorbell_select = qprt_pkg::DB_CQ_HEAD;
          r.doorbell_ptr    = ring_cq_head;
          ring_cq_db = ring_cq_head;
        end
      end
    endcase
    return r;
  endfunction

  function automatic qprt_pkg::qprt_result_t outcome(
      logic acc, logic full, logic [qprt_pkg::PtrW-1:0] slot,
      logic dbw, qprt_pkg::db_sel_e sel, logic [qprt_pkg::PtrW-1:0] dbv,
      logic [qprt_pkg::CmdIdW-1:0] cid, logic [qprt_pkg::ResultW-1:0] res,
      logic [qprt_pkg::CodeW-1:0] code);
    qprt_pkg::qprt_result_t r;
    r.accepted        = acc;
    r.queue_full      = full;
    r.sq_slot         = slot;
    r.doorbell_write  = dbw;
    r.doorbell_select = sel;
    r.doorbell_ptr    = dbv;
    r.cpl_command_id  = cid;
    r.cpl_result      = res;
    r.cpl_status      = code;
    return r;
  endfunction

  function automatic void add_req(qprt_pkg::req_type_e rt, logic [qprt_pkg::StatusW-1:0] st,
                                  logic [qprt_pkg::PtrW-1:0] sqh,
                                  logic [qprt_pkg::CmdIdW-1:0] cid,
                                  logic [qprt_pkg::ResultW-1:0] res,
                                  bit typed = 1'b0, qprt_pkg::qprt_result_t want = '0);
    plan_row_t row;
    row = '0;
    row.kind              = ROW_REQ;
    row.rq.req_type       = rt;
    row.rq.cqe_status     = st;
    row.rq.cqe_sq_head    = sqh;
    row.rq.cqe_command_id = cid;
    row.rq.cqe_result     = res;
    row.typed             = typed;
    row.want              = want;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [qprt_pkg::DepthW-1:0] d);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.depth = d;
    directed_plan.push_back(row);
  endfunction

  // Random request, biased towards well-formed completions (right phase, plausible head).
  function automatic qprt_pkg::qprt_req_t random_request(input int unsigned submit_pct);
    qprt_pkg::qprt_req_t rq;
    int unsigned         pick;
    rq.req_type       = qprt_pkg::REQ_FLUSH_CQ;
    rq.cqe_status     = 16'($urandom);
    rq.cqe_sq_head    = 8'($urandom);
    rq.cqe_command_id = 16'($urandom);
    rq.cqe_result     = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < submit_pct) begin
      rq.req_type = qprt_pkg::REQ_SUBMIT;
    end else if (pick < submit_pct + 8) begin
      rq.req_type = qprt_pkg::REQ_FLUSH_SQ;
    end else if (pick < 92) begin
      rq.req_type = qprt_pkg::REQ_OFFER_CQ;
      if ($urandom_range(0, 99) < 85) begin
        rq.cqe_status[0] = ring_cq_phase;
        pick = $urandom_range(0, 99);
        if (pick < 50) rq.cqe_sq_head = ring_sq_tail;
        else if (pick < 85) rq.cqe_sq_head = ring_sq_head;
      end
    end
    // With one command or none in flight the head is reported as caught up: an
    // arbitrary head here could leave a full ring with nothing left to complete.
    if (ring_inflight <= 9'd1) rq.cqe_sq_head = ring_sq_tail;
    return rq;
  endfunction

  function automatic void log_fault(string msg);
    fault_count++;
    if (fault_count <= ReportMax) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) log_fault($sformatf("%s expected %0h got %0h", fname, want, got));
  endfunction

  // Drive one request, hold it until taken, log what it should produce, then idle for a random gap unless gaps are off.
  task automatic send_request(input qprt_pkg::qprt_req_t rq, input bit typed = 1'b0,
                              input qprt_pkg::qprt_result_t typed_want = '0);
    qprt_pkg::qprt_result_t predicted;
    int unsigned            gap;
    start_i          <= 1'b1;
    req_type_i       <= rq.req_type;
    cqe_status_i     <= rq.cqe_status;
    cqe_sq_head_i    <= rq.cqe_sq_head;
    cqe_command_id_i <= rq.cqe_command_id;
    cqe_result_i     <= rq.cqe_result;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = ring_response(rq);
    resp_due.push_back(typed ? typed_want : predicted);
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Every request yields a response, so an empty queue means nothing is in flight.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (resp_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [qprt_pkg::DepthW-1:0] d);
    wait_drained();
    cfg_valid_i       <= 1'b1;
    cfg_queue_depth_i <= d;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    ring_depth_reg = d;
    cfg_valid_i <= 1'b0;
  endtask

  // Responses are captured in the cycle the strobe is up; the receiver never stalls.
  always @(posedge clk_i) begin : result_check
    qprt_pkg::qprt_result_t want;
    if (done_o === 1'b1) begin
      if (resp_due.size() == 0) begin
        log_fault("response with no request outstanding");
      end else begin
        want = resp_due.pop_front();
        check_field("accepted", want.accepted, accepted_o);
        check_field("queue_full", want.queue_full, queue_full_o);
        check_field("sq_slot", want.sq_slot, sq_slot_o);
        check_field("doorbell_write", want.doorbell_write, doorbell_write_o);
        check_field("doorbell_select", want.doorbell_select, doorbell_select_o);
        check_field("doorbell_ptr", want.doorbell_ptr, doorbell_ptr_o);
        check_field("cpl_command_id", want.cpl_command_id, cpl_command_id_o);
        check_field("cpl_result", want.cpl_result, cpl_result_o);
        check_field("cpl_status", want.cpl_status, cpl_status_o);
      end
    end
  end

  // Hang detector: any handshake or response strobe counts as progress.
  always @(posedge clk_i) begin : watchdog
    if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1 ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("tb_queue_pair_ring_tracker failed");
      $finish;
    end
  end

  initial begin : stimulus
    qprt_pkg::qprt_req_t rq;

    // Directed table. Typed expectations sit on rows whose outcome is plain from the
    // state: reset, refusals, first slots and doorbells. The rest use the shadow model.
    // Fresh from reset nothing has moved and nothing is in flight.
    add_req(qprt_pkg::REQ_FLUSH_SQ, '1, '1, '1, '1, 1'b1);
    add_req(qprt_pkg::REQ_FLUSH_CQ, '0, '0, '0, '0, 1'b1);
    add_req(qprt_pkg::REQ_OFFER_CQ, '1, '1, '1, '1, 1'b1);            // nothing outstanding
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0, 1'b1,
            outcome(1'b1, 1'b0, 8'd0, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_req(qprt_pkg::REQ_FLUSH_SQ, '0, '0, '0, '0, 1'b1,
            outcome(1'b0, 1'b0, 8'd0, 1'b1, qprt_pkg::DB_SQ_TAIL, 8'd1, '0, '0, '0));
    add_req(qprt_pkg::REQ_FLUSH_SQ, '0, '0, '0, '0, 1'b1);            // tail unchanged
    add_req(qprt_pkg::REQ_OFFER_CQ, 16'h0000, '0, '0, '0, 1'b1);      // phase mismatch
    add_req(qprt_pkg::REQ_OFFER_CQ, 16'hFFFF, 8'hFF, 16'hFFFF, '1, 1'b1,
            outcome(1'b1, 1'b0, 8'd0, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, 16'hFFFF, '1,
                    15'h7FFF));
    add_req(qprt_pkg::REQ_FLUSH_CQ, '0, '0, '0, '0, 1'b1,
            outcome(1'b0, 1'b0, 8'd0, 1'b1, qprt_pkg::DB_CQ_HEAD, 8'd1, '0, '0, '0));
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0, 1'b1,
            outcome(1'b1, 1'b0, 8'd1, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_cfg(9'd0);                                                    // clamps to two entries
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0, 1'b1,               // tail already past depth
            outcome(1'b1, 1'b0, 8'd2, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_req(qprt_pkg::REQ_OFFER_CQ, 16'h0001, 8'h00, 16'h0000, '0, 1'b1,  // wraps, phase flips
            outcome(1'b1, 1'b0, 8'd0, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0, 1'b1,
            outcome(1'b1, 1'b0, 8'd0, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0, 1'b1,               // ring full
            outcome(1'b0, 1'b1, 8'd0, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_req(qprt_pkg::REQ_OFFER_CQ, 16'h0001, '0, '0, '0, 1'b1);      // old phase now stale
    add_req(qprt_pkg::REQ_OFFER_CQ, 16'hAAAA, 8'h01, 16'h1234, 64'h0123_4567_89AB_CDEF,
            1'b1,
            outcome(1'b1, 1'b0, 8'd0, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, 16'h1234,
                    64'h0123_4567_89AB_CDEF, 15'h5555));
    add_req(qprt_pkg::REQ_FLUSH_CQ, '0, '0, '0, '0, 1'b1);            // head back where written
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0, 1'b1,
            outcome(1'b1, 1'b0, 8'd1, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_req(qprt_pkg::REQ_FLUSH_SQ, '0, '0, '0, '0, 1'b1,
            outcome(1'b0, 1'b0, 8'd0, 1'b1, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_cfg(9'd511);                                                  // clamps to 256
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0, 1'b1,
            outcome(1'b0, 1'b1, 8'd0, 1'b0, qprt_pkg::DB_SQ_TAIL, 8'd0, '0, '0, '0));
    add_req(qprt_pkg::REQ_OFFER_CQ, 16'h5554, 8'h80, 16'h8000, 64'h8000_0000_0000_0000);
    add_req(qprt_pkg::REQ_SUBMIT, '0, '0, '0, '0);
    add_cfg(9'd3);
    add_req(qprt_pkg::REQ_SUBMIT, 16'h7FFF, 8'h7F, 16'h7FFF, 64'h7FFF_FFFF_FFFF_FFFF);
    add_req(qprt_pkg::REQ_FLUSH_CQ, '0, '0, '0, '0);
    add_req(qprt_pkg::REQ_OFFER_CQ, 16'h0000, 8'h00, 16'h0001, 64'h1);

    phase_depths[10] = 9'($urandom_range(2, 256));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_depth(directed_plan[i].depth);
      end else begin
        send_request(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases: each starts from an idle block with a new depth; every third runs
    // back to back, the others with a random gap after each request.
    for (int ph = 0; ph < 12; ph++) begin
      write_depth(phase_depths[ph]);
      no_gaps = (ph % 3 == 1);
      repeat (14) send_request(random_request(submit_mix[ph % 3]));
    end

    // Saturation: a reported head beyond a four-entry ring means the ring never fills,
    // so a long run of submits drives the outstanding count into its ceiling.
    write_depth(9'd4);
    no_gaps = 1'b1;
    while (ring_sq_head != 8'd200) begin
      rq = random_request(100);
      if (ring_inflight != '0) begin
        rq.req_type      = qprt_pkg::REQ_OFFER_CQ;
        rq.cqe_status[0] = ring_cq_phase;
        rq.cqe_sq_head   = 8'd200;
      end
      send_request(rq);
    end
    for (int n = 0; n < 530; n++) begin
      rq = random_request(100);
      if (n % 53 == 0) rq.req_type = qprt_pkg::REQ_FLUSH_SQ;
      send_request(rq);
    end
    no_gaps = 1'b0;
    repeat (30) send_request(random_request(45));

    wait_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    if (fault_count == 0) begin
      $display("tb_queue_pair_ring_tracker passed");
    end else begin
      $display("tb_queue_pair_ring_tracker failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/qprt_pkg.sv
sv/qprt_engine.sv
sv/qprt_out_reg.sv
sv/queue_pair_ring_tracker.sv
tb/tb_queue_pair_ring_tracker.sv
